// ===== hdl/ptx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptx_pkg;

  localparam int InW      = 16;
  localparam int PW       = 18;
  localparam int CW       = 37;
  localparam int TW       = PW + CW;
  localparam int DW       = 56;
  localparam int HW       = DW / 2;
  localparam int XW       = 33;
  localparam int NW       = 93;
  localparam int DenW     = 72;
  localparam int QW       = 24;
  localparam int RW       = DenW + QW;
  localparam int Lanes    = 9;
  localparam int FwdShift = 4;
  localparam int InvShift = 28;

  localparam logic [PW-1:0] OneQ16 = PW'(65536);
  localparam logic [QW-1:0] LimPos = QW'(8388607);
  localparam logic [QW-1:0] LimNeg = QW'(8388608);

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusDegen = 2'd1,
    StatusSat   = 2'd2
  } status_t;

  typedef logic signed [PW-1:0] ps_t;
  typedef logic signed [CW-1:0] cs_t;
  typedef logic signed [DW-1:0] ds_t;
  typedef logic signed [QW-1:0] coef_t;

  typedef struct packed {
    logic [2:0][InW-1:0] px;
    logic [2:0][InW-1:0] py;
    logic [InW-1:0]      wx;
    logic [InW-1:0]      wy;
    logic [InW-1:0]      lum;
  } prim_t;

  typedef struct packed {
    ps_t [2:0][2:0] p;
    cs_t [2:0][2:0] c;
    logic [InW-1:0] wy;
    logic [InW-1:0] lum;
    ds_t            det;
    ds_t [2:0]      a;
  } det_t;

  typedef struct packed {
    logic [NW:0]   num;
    logic [DenW:0] den;
    logic          neg;
    logic          sat;
  } lane_t;

  typedef struct packed {
    lane_t [Lanes-1:0] lane;
    logic              degen;
  } scale_t;

endpackage
`default_nettype wire

// ===== hdl/ptx_det.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_det (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire ptx_pkg::prim_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ptx_pkg::det_t       out_data
);
  import ptx_pkg::*;

  ps_t                    pm [3][3];
  ps_t                    wm [3];
  logic signed [2*PW-1:0] m1 [3][3];
  logic signed [2*PW-1:0] m2 [3][3];
  cs_t                    cm [3][3];

  logic                 s1_valid;
  ps_t                  s1_p [3][3];
  cs_t                  s1_c [3][3];
  ps_t                  s1_w [3];
  logic [InW-1:0]       s1_lum;
  logic                 s2_valid;
  logic signed [TW-1:0] s2_t [3];
  logic signed [TW-1:0] s2_u [3][3];
  ps_t                  s2_p [3][3];
  cs_t                  s2_c [3][3];
  logic [InW-1:0]       s2_wy;
  logic [InW-1:0]       s2_lum;
  logic                 en1, en2, en3;

  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    int r1, r2, k1, k2;
    for (int j = 0; j < 3; j++) begin
      pm[0][j] = PW'(in_data.px[j]);
      pm[1][j] = PW'(in_data.py[j]);
      pm[2][j] = ps_t'(OneQ16 - PW'(in_data.px[j]) - PW'(in_data.py[j]));
    end
    wm[0] = PW'(in_data.wx);
    wm[1] = PW'(in_data.wy);
    wm[2] = ps_t'(OneQ16 - PW'(in_data.wx) - PW'(in_data.wy));
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        r1 = (r == 2) ? 0 : r + 1;
        r2 = (r == 0) ? 2 : r - 1;
        k1 = (k == 2) ? 0 : k + 1;
        k2 = (k == 0) ? 2 : k - 1;
        m1[r][k] = pm[r1][k1] * pm[r2][k2];
        m2[r][k] = pm[r1][k2] * pm[r2][k1];
        cm[r][k] = CW'(m1[r][k]) - CW'(m2[r][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_p   <= pm;
      s1_c   <= cm;
      s1_w   <= wm;
      s1_lum <= in_data.lum;
    end
    if (en2) begin
      for (int k = 0; k < 3; k++) s2_t[k] <= s1_p[0][k] * s1_c[0][k];
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) s2_u[r][j] <= s1_c[r][j] * s1_w[r];
      end
      s2_p   <= s1_p;
      s2_c   <= s1_c;
      s2_wy  <= s1_w[1][InW-1:0];
      s2_lum <= s1_lum;
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          out_data.p[i][j] <= s2_p[i][j];
          out_data.c[i][j] <= s2_c[i][j];
        end
      end
      out_data.wy  <= s2_wy;
      out_data.lum <= s2_lum;
      out_data.det <= DW'(s2_t[0]) + DW'(s2_t[1]) + DW'(s2_t[2]);
      for (int j = 0; j < 3; j++) begin
        out_data.a[j] <= DW'(s2_u[0][j]) + DW'(s2_u[1][j]) + DW'(s2_u[2][j]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ptx_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_scale (
  input  wire                clk,
  input  wire                rst,
  input  wire                inverse,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire ptx_pkg::det_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output ptx_pkg::scale_t    out_data
);
  import ptx_pkg::*;

  localparam int PxW = XW + HW;
  localparam int PsW = InW + HW;

  function automatic logic [DW-1:0] mag_d(input ds_t v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [CW-1:0] mag_c(input cs_t v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  function automatic logic [PW-1:0] mag_p(input ps_t v);
    return v[PW-1] ? PW'(-v) : PW'(v);
  endfunction

  logic [XW-1:0]  x0 [Lanes];
  logic [DW-1:0]  y0 [Lanes];
  logic [InW-1:0] u0 [Lanes];
  logic [DW-1:0]  t0 [Lanes];
  logic           neg0 [Lanes];
  logic           degen0;

  logic           s1_valid;
  logic [XW-1:0]  s1_x [Lanes];
  logic [DW-1:0]  s1_y [Lanes];
  logic [InW-1:0] s1_u [Lanes];
  logic [DW-1:0]  s1_t [Lanes];
  logic           s1_neg [Lanes];
  logic           s1_degen;

  logic           s2_valid;
  logic [PxW-1:0] s2_xl [Lanes];
  logic [PxW-1:0] s2_xh [Lanes];
  logic [PsW-1:0] s2_ul [Lanes];
  logic [PsW-1:0] s2_uh [Lanes];
  logic           s2_neg [Lanes];
  logic           s2_degen;

  logic [NW-1:0]   prod2 [Lanes];
  logic [DenW-1:0] dsum2 [Lanes];

  logic            s3_valid;
  logic [NW-1:0]   s3_n [Lanes];
  logic [DenW-1:0] s3_d [Lanes];
  logic            s3_neg [Lanes];
  logic            s3_degen;

  logic [NW:0]   num3 [Lanes];
  logic [DenW:0] den3 [Lanes];
  logic [RW-1:0] lim3 [Lanes];

  logic en1, en2, en3, en4;

  assign en4      = !out_valid || out_ready;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    int l;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        l = i * 3 + j;
        if (!inverse) begin
          x0[l]   = XW'(mag_p(in_data.p[i][j])) * XW'(in_data.lum);
          y0[l]   = mag_d(in_data.a[j]);
          neg0[l] = in_data.p[i][j][PW-1] ^ in_data.a[j][DW-1] ^ in_data.det[DW-1];
          u0[l]   = in_data.wy;
          t0[l]   = mag_d(in_data.det);
        end else begin
          x0[l]   = XW'(in_data.wy);
          y0[l]   = DW'(mag_c(in_data.c[j][i]));
          neg0[l] = in_data.c[j][i][CW-1] ^ in_data.a[i][DW-1];
          u0[l]   = in_data.lum;
          t0[l]   = mag_d(in_data.a[i]);
        end
      end
    end
    degen0 = (in_data.wy == '0) || (in_data.det == '0) ||
             (inverse && ((in_data.lum == '0) || (in_data.a[0] == '0) ||
                          (in_data.a[1] == '0) || (in_data.a[2] == '0)));
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      prod2[l] = (NW'(s2_xh[l]) << HW) + NW'(s2_xl[l]);
      dsum2[l] = (DenW'(s2_uh[l]) << HW) + DenW'(s2_ul[l]);
      num3[l]  = ((NW+1)'(s3_n[l]) << 1) + (NW+1)'(s3_d[l]);
      den3[l]  = (DenW+1)'(s3_d[l]) << 1;
      lim3[l]  = (RW'(den3[l]) << (QW - 1)) + (s3_neg[l] ? RW'(den3[l]) : RW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_x     <= x0;
      s1_y     <= y0;
      s1_u     <= u0;
      s1_t     <= t0;
      s1_neg   <= neg0;
      s1_degen <= degen0;
    end
    if (en2) begin
      for (int l = 0; l < Lanes; l++) begin
        s2_xl[l] <= PxW'(s1_x[l]) * PxW'(s1_y[l][HW-1:0]);
        s2_xh[l] <= PxW'(s1_x[l]) * PxW'(s1_y[l][DW-1:HW]);
        s2_ul[l] <= PsW'(s1_u[l]) * PsW'(s1_t[l][HW-1:0]);
        s2_uh[l] <= PsW'(s1_u[l]) * PsW'(s1_t[l][DW-1:HW]);
      end
      s2_neg   <= s1_neg;
      s2_degen <= s1_degen;
    end
    if (en3) begin
      for (int l = 0; l < Lanes; l++) begin
        s3_n[l] <= inverse ? (prod2[l] << InvShift) : (prod2[l] << FwdShift);
        s3_d[l] <= dsum2[l];
      end
      s3_neg   <= s2_neg;
      s3_degen <= s2_degen;
    end
    if (en4) begin
      for (int l = 0; l < Lanes; l++) begin
        out_data.lane[l].num <= num3[l];
        out_data.lane[l].den <= den3[l];
        out_data.lane[l].neg <= s3_neg[l];
        out_data.lane[l].sat <= RW'(num3[l]) >= lim3[l];
      end
      out_data.degen <= s3_degen;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ptx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_div (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire ptx_pkg::scale_t                      in_data,
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output ptx_pkg::coef_t [ptx_pkg::Lanes-1:0]       out_coef,
  output ptx_pkg::status_t                          out_status
);
  import ptx_pkg::*;

  logic [Lanes-1:0][RW-1:0]   rem [QW];
  logic [Lanes-1:0][QW-1:0]   quo [QW];
  logic [Lanes-1:0][DenW:0]   dvs [QW];
  logic [Lanes-1:0]           neg [QW];
  logic [Lanes-1:0]           sat [QW];
  logic                       dgn [QW];
  logic [QW-1:0]              vld;

  logic [Lanes-1:0][RW-1:0]   src_rem [QW];
  logic [Lanes-1:0][QW-1:0]   src_quo [QW];
  logic [Lanes-1:0][DenW:0]   src_dvs [QW];
  logic [Lanes-1:0]           src_neg [QW];
  logic [Lanes-1:0]           src_sat [QW];
  logic                       src_dgn [QW];
  logic [Lanes-1:0][RW-1:0]   nxt_rem [QW];
  logic [Lanes-1:0][QW-1:0]   nxt_quo [QW];

  coef_t [Lanes-1:0] coef_next;
  status_t           status_next;
  logic [QW:0]       en;

  always_comb begin
    en[QW] = !out_valid || out_ready;
    for (int s = QW - 1; s >= 0; s--) en[s] = !vld[s] || en[s+1];
  end
  assign in_ready = en[0];

  always_comb begin
    logic [RW-1:0] shifted;
    logic          ge;
    for (int l = 0; l < Lanes; l++) begin
      src_rem[0][l] = RW'(in_data.lane[l].num);
      src_quo[0][l] = '0;
      src_dvs[0][l] = in_data.lane[l].den;
      src_neg[0][l] = in_data.lane[l].neg;
      src_sat[0][l] = in_data.lane[l].sat;
    end
    src_dgn[0] = in_data.degen;
    for (int s = 1; s < QW; s++) begin
      src_rem[s] = rem[s-1];
      src_quo[s] = quo[s-1];
      src_dvs[s] = dvs[s-1];
      src_neg[s] = neg[s-1];
      src_sat[s] = sat[s-1];
      src_dgn[s] = dgn[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        shifted       = RW'(src_dvs[s][l]) << (QW - 1 - s);
        ge            = src_rem[s][l] >= shifted;
        nxt_rem[s][l] = ge ? src_rem[s][l] - shifted : src_rem[s][l];
        nxt_quo[s][l] = src_quo[s][l] | (QW'(ge) << (QW - 1 - s));
      end
    end
  end

  always_comb begin
    logic [QW-1:0] mag;
    for (int l = 0; l < Lanes; l++) begin
      mag = sat[QW-1][l] ? (neg[QW-1][l] ? LimNeg : LimPos) : quo[QW-1][l];
      if (dgn[QW-1]) begin
        coef_next[l] = '0;
      end else begin
        coef_next[l] = neg[QW-1][l] ? coef_t'(-mag) : coef_t'(mag);
      end
    end
    if (dgn[QW-1]) begin
      status_next = StatusDegen;
    end else if (|sat[QW-1]) begin
      status_next = StatusSat;
    end else begin
      status_next = StatusOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < QW; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
      if (en[QW]) out_valid <= vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      if (en[s]) begin
        rem[s] <= nxt_rem[s];
        quo[s] <= nxt_quo[s];
        dvs[s] <= src_dvs[s];
        neg[s] <= src_neg[s];
        sat[s] <= src_sat[s];
        dgn[s] <= src_dgn[s];
      end
    end
    if (en[QW]) begin
      out_coef   <= coef_next;
      out_status <= status_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/primaries_to_xyz_matrix.sv =====
// RGB-to-XYZ matrix from primaries and white point, or its inverse.
// Input channel: in_valid / in_ready carry one item of nine chromaticity and
// luminance fields. Output channel: out_valid / out_ready carry the nine
// signed Q8.16 coefficients and a status code (ok, degenerate, saturated).
// cfg_write with cfg_data sets inverse_mode; write it only while idle.
// From acceptance to out_valid an item passes three stages that form the
// cofactors, determinant and white-weighted sums, four stages that form the
// magnitude products and the saturation test, and a 24-stage restoring
// divider with one quotient bit per stage feeds the output register.
// Throughput is one item per cycle in every mode while out_ready stays high.
// Reset clears inverse_mode and every valid bit; the pipeline is then empty.
// When the receiver stalls, the output register holds its item and each
// stage fills its bubble before in_ready falls; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module primaries_to_xyz_matrix (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire         cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] red_x,
  input  wire  [15:0] red_y,
  input  wire  [15:0] green_x,
  input  wire  [15:0] green_y,
  input  wire  [15:0] blue_x,
  input  wire  [15:0] blue_y,
  input  wire  [15:0] white_x,
  input  wire  [15:0] white_y,
  input  wire  [15:0] luminance,
  output logic        out_valid,
  input  wire         out_ready,
  output logic signed [23:0] coef_r0_c0,
  output logic signed [23:0] coef_r0_c1,
  output logic signed [23:0] coef_r0_c2,
  output logic signed [23:0] coef_r1_c0,
  output logic signed [23:0] coef_r1_c1,
  output logic signed [23:0] coef_r1_c2,
  output logic signed [23:0] coef_r2_c0,
  output logic signed [23:0] coef_r2_c1,
  output logic signed [23:0] coef_r2_c2,
  output logic        [1:0]  status
);
  import ptx_pkg::*;

  logic              inverse_mode;
  prim_t             prim;
  det_t              det_data;
  logic              det_valid, det_ready;
  scale_t            scale_data;
  logic              scale_valid, scale_ready;
  coef_t [Lanes-1:0] coef;
  status_t           st;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (cfg_write) begin
      inverse_mode <= cfg_data;
    end
  end

  assign prim.px  = {blue_x, green_x, red_x};
  assign prim.py  = {blue_y, green_y, red_y};
  assign prim.wx  = white_x;
  assign prim.wy  = white_y;
  assign prim.lum = luminance;

  ptx_det u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (prim),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .out_data  (det_data)
  );

  ptx_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .inverse   (inverse_mode),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .in_data   (det_data),
    .out_valid (scale_valid),
    .out_ready (scale_ready),
    .out_data  (scale_data)
  );

  ptx_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (scale_valid),
    .in_ready   (scale_ready),
    .in_data    (scale_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_coef   (coef),
    .out_status (st)
  );

  assign coef_r0_c0 = coef[0];
  assign coef_r0_c1 = coef[1];
  assign coef_r0_c2 = coef[2];
  assign coef_r1_c0 = coef[3];
  assign coef_r1_c1 = coef[4];
  assign coef_r1_c2 = coef[5];
  assign coef_r2_c0 = coef[6];
  assign coef_r2_c1 = coef[7];
  assign coef_r2_c2 = coef[8];
  assign status     = st;

endmodule
`default_nettype wire

// ===== tb/tb_primaries_to_xyz_matrix.sv =====
`timescale 1ns / 1ps
module tb_primaries_to_xyz_matrix;
  import ptx_pkg::*;

  typedef struct {
    logic [15:0] f[9];
    logic        known;
    status_t     st;
  } stim_row_t;

  typedef struct {
    logic signed [23:0] coef[9];
    status_t            st;
  } matrix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] fld[9];
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [23:0] coef[9];
  logic [1:0]  status;

  logic        inv_mode = 1'b0;
  matrix_t     pending[$];
  stim_row_t   rows[$];
  int          errors = 0;
  int          burst = 0;

  initial for (int k = 0; k < 9; k++) fld[k] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  primaries_to_xyz_matrix DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .red_x(fld[0]), .red_y(fld[1]), .green_x(fld[2]), .green_y(fld[3]),
    .blue_x(fld[4]), .blue_y(fld[5]), .white_x(fld[6]), .white_y(fld[7]),
    .luminance(fld[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .coef_r0_c0(coef[0]), .coef_r0_c1(coef[1]), .coef_r0_c2(coef[2]),
    .coef_r1_c0(coef[3]), .coef_r1_c1(coef[4]), .coef_r1_c2(coef[5]),
    .coef_r2_c0(coef[6]), .coef_r2_c1(coef[7]), .coef_r2_c2(coef[8]),
    .status(status)
  );

  function automatic logic [129:0] mag64(longint v, inout logic neg);
    if (v < 0) begin
      neg = !neg;
      return 130'(-v);
    end
    return 130'(v);
  endfunction

  function automatic matrix_t predict_matrix(logic [15:0] f[9], logic inv);
    matrix_t     m;
    longint      p[3][3], c[3][3], w[3], a[3], det, lum;
    logic        degen, sat, neg;
    logic [129:0] n, d, q;
    int          r1, r2, k1, k2;
    lum = longint'(f[8]);
    for (int j = 0; j < 3; j++) begin
      p[0][j] = longint'(f[2*j]);
      p[1][j] = longint'(f[2*j+1]);
      p[2][j] = 65536 - p[0][j] - p[1][j];
    end
    w[0] = longint'(f[6]);
    w[1] = longint'(f[7]);
    w[2] = 65536 - w[0] - w[1];
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        r1 = (r + 1) % 3; r2 = (r + 2) % 3; k1 = (k + 1) % 3; k2 = (k + 2) % 3;
        c[r][k] = p[r1][k1] * p[r2][k2] - p[r1][k2] * p[r2][k1];
      end
    det = p[0][0] * c[0][0] + p[0][1] * c[0][1] + p[0][2] * c[0][2];
    for (int j = 0; j < 3; j++) a[j] = c[0][j] * w[0] + c[1][j] * w[1] + c[2][j] * w[2];
    degen = (w[1] == 0) || (det == 0);
    if (inv && (lum == 0 || a[0] == 0 || a[1] == 0 || a[2] == 0)) degen = 1'b1;
    sat = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        m.coef[i*3+j] = '0;
        if (!degen) begin
          neg = 1'b0;
          if (!inv) begin
            n = mag64(p[i][j], neg) * mag64(a[j], neg) * 130'(lum) * 130'(16);
            d = mag64(w[1], neg) * mag64(det, neg);
          end else begin
            n = 130'(268435456) * 130'(w[1]) * mag64(c[j][i], neg);
            d = mag64(a[i], neg) * 130'(lum);
          end
          q = (2 * n + d) / (2 * d);
          if (q > (neg ? 130'(8388608) : 130'(8388607))) begin
            sat = 1'b1;
            q = neg ? 130'(8388608) : 130'(8388607);
          end
          m.coef[i*3+j] = neg ? -24'(q) : 24'(q);
        end
      end
    m.st = degen ? StatusDegen : (sat ? StatusSat : StatusOk);
    return m;
  endfunction

  task automatic report(string what, int idx, longint got, longint want);
    $display("mismatch %s[%0d]: got %0d, want %0d", what, idx, got, want);
    errors++;
  endtask

  task automatic send_item(logic [15:0] f[9], logic known, status_t st);
    matrix_t m;
    int gap;
    for (int k = 0; k < 9; k++) fld[k] <= f[k];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    m = predict_matrix(f, inv_mode);
    if (known) begin
      if (m.st != st) report("table status", 0, m.st, st);
      m.st = st;
      for (int k = 0; k < 9; k++) m.coef[k] = '0;
    end
    pending.push_back(m);
    gap = (burst > 0) ? 0 : $urandom_range(0, 9);
    if (burst > 0) burst--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_set(logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    inv_mode = mode;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(int rx, int ry, int gx, int gy, int bx, int by,
                         int wx, int wy, int lm, logic known);
    stim_row_t s;
    s.f[0] = 16'(rx); s.f[1] = 16'(ry); s.f[2] = 16'(gx); s.f[3] = 16'(gy);
    s.f[4] = 16'(bx); s.f[5] = 16'(by); s.f[6] = 16'(wx); s.f[7] = 16'(wy);
    s.f[8] = 16'(lm);
    s.known = known;
    s.st = StatusDegen;
    rows.push_back(s);
  endtask

  task automatic random_items(int count);
    logic [15:0] f[9];
    int kind;
    for (int n = 0; n < count; n++) begin
      if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(5, 30);
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 8; k += 2) begin
        f[k]   = 16'($urandom_range(1000, 45000));
        f[k+1] = 16'($urandom_range(1000, 65536 - 1000 - f[k]));
      end
      f[8] = 16'($urandom_range(1, 16384));
      if (kind == 0) begin
        for (int k = 0; k < 9; k++) f[k] = 16'($urandom());
      end else if (kind == 1) begin
        f[2] = f[0]; f[3] = f[1];
      end else if (kind == 2) begin
        f[7] = 16'($urandom_range(0, 3));
        f[8] = 16'($urandom());
      end else if (kind == 3) begin
        f[8] = $urandom_range(0, 1) ? 16'd0 : 16'hffff;
      end
      send_item(f, 1'b0, StatusOk);
    end
  endtask

  initial begin
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    add_row(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 1'b1);
    add_row(41943, 21627, 19661, 39322, 9830, 3932, 20493, 0, 4096, 1'b1);
    add_row(41943, 21627, 41943, 21627, 9830, 3932, 20493, 21561, 4096, 1'b1);
    add_row(41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561, 4096, 1'b0);
    add_row(41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561, 0, 1'b0);
    add_row(41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561, 65535, 1'b0);
    add_row(41943, 21627, 19661, 39322, 9830, 3932, 20493, 1, 65535, 1'b0);
    add_row(65535, 0, 0, 65535, 0, 0, 21845, 21845, 4096, 1'b0);
    add_row(65535, 0, 0, 65535, 0, 0, 0, 65535, 4096, 1'b0);
    add_row(65535, 65535, 0, 0, 0, 65535, 65535, 65535, 65535, 1'b0);
    add_row(1, 2, 3, 4, 5, 7, 65535, 1, 1, 1'b0);
    add_row(46000, 19000, 17000, 52000, 9000, 3000, 21000, 22000, 4096, 1'b0);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) drain_and_set(ph[0]);
      if (ph < 2)
        foreach (rows[r]) send_item(rows[r].f, rows[r].known, rows[r].st);
      random_items(60);
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending.size() != 0) @(posedge clk);
      random_items(65);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("** primaries_to_xyz_matrix: PASSED **");
    else $display("** primaries_to_xyz_matrix: FAILED **");
    $finish;
  end

  initial begin
    matrix_t m;
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending.size() == 0) begin
        report("unexpected item", 0, status, 0);
      end else begin
        m = pending.pop_front();
        for (int k = 0; k < 9; k++)
          if (coef[k] !== m.coef[k]) report("coef", k, coef[k], m.coef[k]);
        if (status !== m.st) report("status", 0, status, m.st);
      end
    end
  end

  initial begin
    #5ms;
    $display("** primaries_to_xyz_matrix: FAILED **");
    $finish;
  end
endmodule
